@@ sv/ipx_pkg.sv @@
// ----------------------------------------------------------------------------
// ipx_pkg
// Shared constants, codes and types of the indexed pixel line expander.
// ----------------------------------------------------------------------------
package ipx_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int ACTIVE_WIDTH    = 320;
  localparam int LINE_WIDTH      = 360;
  localparam int MAX_PITCH       = 4096;

  localparam int PAL_AW       = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int MARGIN_TOTAL = (LINE_WIDTH > ACTIVE_WIDTH) ? (LINE_WIDTH - ACTIVE_WIDTH) : 0;
  localparam int LEFT_MARGIN  = MARGIN_TOTAL / 2;
  localparam int RIGHT_MARGIN = MARGIN_TOTAL - LEFT_MARGIN;
  localparam int MCNT_W       = (RIGHT_MARGIN > 1) ? $clog2(RIGHT_MARGIN + 1) : 1;

  localparam int COL_W   = 12;
  localparam int ROW_W   = 10;
  localparam int PITCH_W = 13;
  localparam int BLANK_W = 10;
  localparam int CFG_W   = 13;
  localparam int RGB_W   = 24;
  localparam int PIX_W   = 16;
  localparam int IDX_W   = 8;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 16;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Input item kinds (tuser)
  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_PIXEL   = 1'b1;

  // Configuration register indexes
  localparam logic CFG_SOURCE_PITCH = 1'b0;
  localparam logic CFG_BLANK_ROWS   = 1'b1;

  typedef enum logic {
    CMD_WRITE,
    CMD_PIXEL
  } cmd_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LEFT,
    BK_PIX,
    BK_RIGHT
  } back_state_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [PAL_AW-1:0]  addr;
    logic [PIX_W-1:0]   data;
    logic               blank;
    logic               first_col;
    logic               last_col;
  } cmd_t;

  function automatic logic [PIX_W-1:0] to_rgb565(input logic [RGB_W-1:0] rgb);
    to_rgb565 = {rgb[23:19], rgb[15:10], rgb[7:3]};
  endfunction

endpackage

@@ sv/indexed_pixel_line_expander.sv @@
// ----------------------------------------------------------------------------
// indexed_pixel_line_expander
// Palette lookup of 8-bit framebuffer indices into RGB565 display lines.
// ----------------------------------------------------------------------------
// Input stream: tuser selects a palette write (0) or a pixel byte (1). Palette
// writes store the truncated RGB565 color and emit nothing. Pixel bytes in the
// first 320 columns of a row emit one beat each; the first is preceded by 20
// black beats and the last followed by 20, giving 360-beat lines. Columns past
// 320 up to source_pitch emit nothing. frame_start restarts row and column.
// Output stream: tdata is the RGB565 pixel, tlast marks the final beat of one
// input item, tuser marks the last beat of a line.
// Config channel: always ready; write only while the block is idle.
// Path: input beat, command queue, palette read, output register. Throughput:
// a pixel pops with its palette read, its beat written before the next pop;
// margin beats one per cycle while the receiver is ready, palette writes one
// per cycle; set by the single-ported palette sequencer in the back end.
// Reset clears counters, queue pointers and tvalid and loads source_pitch 320
// and blank_rows 32; palette contents are undefined until written.
// A stalled receiver holds the output register; the two-entry command queue
// fills and then input tready drops.
// ----------------------------------------------------------------------------
module indexed_pixel_line_expander
  import ipx_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // frame_start, pixel_index, entry_number, entry_rgb, zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // op
  input  logic                 s_axis_tuser,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // pixel_rgb565
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // last_of_run
  output logic                 m_axis_tlast,
  // end_of_line
  output logic                 m_axis_tuser
);

  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic push;
  logic pop;
  logic full;
  logic empty;

  ipx_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  ipx_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (pop_cmd)
  );

  ipx_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .cmd_i         (pop_cmd),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

@@ sv/ipx_front.sv @@
// ----------------------------------------------------------------------------
// ipx_front
// Accepts input beats, holds config and row/column counters, classifies each
// beat into a palette write or a pixel command for the back end.
// ----------------------------------------------------------------------------
module ipx_front
  import ipx_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tuser,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 full_i,
  output logic                 push_o,
  output cmd_t                 cmd_o
);

  logic [PITCH_W-1:0] pitch_q;
  logic [BLANK_W-1:0] blank_q;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;

  logic               frame_start;
  logic [IDX_W-1:0]   pixel_index;
  logic [IDX_W-1:0]   entry_number;
  logic [RGB_W-1:0]   entry_rgb;

  logic               accept;
  logic [PITCH_W-1:0] pitch_eff;
  logic [COL_W-1:0]   col_cur;
  logic [ROW_W-1:0]   row_cur;
  logic [PITCH_W-1:0] col_inc;
  logic               active;
  logic               entry_ok;
  logic               index_ok;

  // tdata: frame_start, pixel_index, entry_number, entry_rgb
  assign frame_start  = s_axis_tdata[0];
  assign pixel_index  = s_axis_tdata[8:1];
  assign entry_number = s_axis_tdata[16:9];
  assign entry_rgb    = s_axis_tdata[40:17];

  assign s_axis_tready = !full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q <= PITCH_W'(320);
      blank_q <= BLANK_W'(32);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SOURCE_PITCH: pitch_q <= cfg_data_i[PITCH_W-1:0];
        CFG_BLANK_ROWS:   blank_q <= cfg_data_i[BLANK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pitch_q < PITCH_W'(ACTIVE_WIDTH)) begin
      pitch_eff = PITCH_W'(ACTIVE_WIDTH);
    end else if (pitch_q > PITCH_W'(MAX_PITCH)) begin
      pitch_eff = PITCH_W'(MAX_PITCH);
    end else begin
      pitch_eff = pitch_q;
    end
  end

  assign col_cur  = frame_start ? '0 : col_q;
  assign row_cur  = frame_start ? '0 : row_q;
  assign col_inc  = {1'b0, col_cur} + PITCH_W'(1);
  assign active   = col_cur < COL_W'(ACTIVE_WIDTH);
  assign entry_ok = {1'b0, entry_number} < (IDX_W + 1)'(PALETTE_ENTRIES);
  assign index_ok = {1'b0, pixel_index} < (IDX_W + 1)'(PALETTE_ENTRIES);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept && (s_axis_tuser == OP_PIXEL)) begin
      if (col_inc >= pitch_eff) begin
        col_d = '0;
        row_d = row_cur + ROW_W'(1);
      end else begin
        col_d = col_inc[COL_W-1:0];
        row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.data      = to_rgb565(entry_rgb);
    cmd_o.blank     = (row_cur < blank_q) || !index_ok;
    cmd_o.first_col = (col_cur == '0);
    cmd_o.last_col  = (col_cur == COL_W'(ACTIVE_WIDTH - 1));
    if (s_axis_tuser == OP_PIXEL) begin
      cmd_o.kind = CMD_PIXEL;
      cmd_o.addr = pixel_index[PAL_AW-1:0];
      push_o     = accept && active;
    end else begin
      cmd_o.kind = CMD_WRITE;
      cmd_o.addr = entry_number[PAL_AW-1:0];
      push_o     = accept && entry_ok;
    end
  end

endmodule

@@ sv/ipx_fifo.sv @@
// ----------------------------------------------------------------------------
// ipx_fifo
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
module ipx_fifo
  import ipx_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  cmd_t                 slot_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q;
  logic [FIFO_AW-1:0]   rd_ptr_q;
  logic [FIFO_AW:0]     count_q;

  assign full_o  = (count_q == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + FIFO_AW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (FIFO_AW + 1)'(1);
        2'b01:   count_q <= count_q - (FIFO_AW + 1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ sv/ipx_back.sv @@
// ----------------------------------------------------------------------------
// ipx_back
// Palette memory and line sequencer: performs palette writes, looks up pixel
// colors and emits margin, pixel and end-of-line beats into the output register.
// ----------------------------------------------------------------------------
module ipx_back
  import ipx_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  cmd_t                 cmd_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic                 m_axis_tlast,
  output logic                 m_axis_tuser
);

  back_state_e       state_q, state_d;
  logic [PIX_W-1:0]  pal_mem [PALETTE_ENTRIES];
  logic [PIX_W-1:0]  rd_data_q;
  logic              blank_q;
  logic              last_col_q;
  logic [MCNT_W-1:0] cnt_q, cnt_d;

  logic              out_valid_q;
  logic [PIX_W-1:0]  out_data_q;
  logic              out_last_q;
  logic              out_eol_q;

  logic              out_free;
  logic              mem_we;
  logic              mem_re;
  logic              emit;
  logic [PIX_W-1:0]  emit_data;
  logic              emit_last;
  logic              emit_eol;
  logic              right_run;

  assign out_free  = !out_valid_q || m_axis_tready;
  assign right_run = last_col_q && (RIGHT_MARGIN > 0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i && (cmd_i.kind == CMD_PIXEL)) begin
          state_d = (cmd_i.first_col && (LEFT_MARGIN > 0)) ? BK_LEFT : BK_PIX;
        end
      end
      BK_LEFT: begin
        if (out_free && (cnt_q == MCNT_W'(1))) begin
          state_d = BK_PIX;
        end
      end
      BK_PIX: begin
        if (out_free) begin
          state_d = right_run ? BK_RIGHT : BK_IDLE;
        end
      end
      BK_RIGHT: begin
        if (out_free && (cnt_q == MCNT_W'(1))) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    emit      = 1'b0;
    emit_data = '0;
    emit_last = 1'b0;
    emit_eol  = 1'b0;
    cnt_d     = cnt_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (cmd_i.kind == CMD_PIXEL) begin
            mem_re = 1'b1;
            cnt_d  = MCNT_W'(LEFT_MARGIN);
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      BK_LEFT: begin
        if (out_free) begin
          emit  = 1'b1;
          cnt_d = cnt_q - MCNT_W'(1);
        end
      end
      BK_PIX: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_data = blank_q ? '0 : rd_data_q;
          emit_last = !right_run;
          // with a right margin the line ends on its last margin beat
          emit_eol  = last_col_q && !right_run;
          cnt_d     = MCNT_W'(RIGHT_MARGIN);
        end
      end
      BK_RIGHT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = (cnt_q == MCNT_W'(1));
          emit_eol  = (cnt_q == MCNT_W'(1));
          cnt_d     = cnt_q - MCNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pal_mem[cmd_i.addr] <= cmd_i.data;
    end
    if (mem_re) begin
      rd_data_q  <= pal_mem[cmd_i.addr];
      blank_q    <= cmd_i.blank;
      last_col_q <= cmd_i.last_col;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= emit_data;
      out_last_q <= emit_last;
      out_eol_q  <= emit_eol;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_eol_q;

endmodule
